>>> rtl/core/diff_drive_pwm_mixer_defines.svh
// Assertion macros for the differential drive PWM mixer.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef DIFF_DRIVE_PWM_MIXER_DEFINES_SVH
`define DIFF_DRIVE_PWM_MIXER_DEFINES_SVH

// Same-cycle implication
`define DPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay
`define DPM_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dpm_pkg.sv
package dpm_pkg;

  localparam int unsigned CMD_W      = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned DUTY_W     = 12;
  localparam int unsigned CHAN_W     = 12;
  localparam int unsigned SIGN_W     = 4;
  localparam int unsigned PAIR_W     = 3;
  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned MAX_WHEELS = 4;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  // Remap arithmetic widths
  localparam int unsigned PROD_W = MAG_W + DUTY_W;  // (mag-dz)*(4095-floor)
  localparam int unsigned REM_W  = PROD_W + 1;      // 2*prod + den
  localparam int unsigned DIV_STAGES = DUTY_W;      // one quotient bit a stage

  localparam logic [MAG_W-1:0]  FULL_CMD  = 15'h7FFF;
  localparam logic [DUTY_W-1:0] FULL_DUTY = 12'hFFF;

  localparam int unsigned DEFAULT_WHEELS = 4;

  // Register reset values
  localparam logic [MAG_W-1:0]  DEADZONE_RST = 15'd1638;
  localparam logic [DUTY_W-1:0] FLOOR_RST    = 12'd1200;
  localparam logic [CHAN_W-1:0] CHAN_RST     = 12'd1944;
  localparam logic [SIGN_W-1:0] SIGNS_RST    = 4'd0;

  // Register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_FLOOR    = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_SIGNS    = 2'd3
  } dpm_reg_e;

  typedef logic [DUTY_W-1:0] dpm_duty_t;

  // Direction flags carried along a lane
  typedef struct packed {
    logic fwd;
    logic rev;
    logic zspan;
  } dpm_flags_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic      fwd;
    logic      rev;
    dpm_duty_t duty;
  } dpm_lane_res_t;

endpackage

>>> rtl/core/dpm_lane.sv
module dpm_lane (
  input  logic                                clk_i,
  input  logic signed [dpm_pkg::CMD_W-1:0]    cmd_i,
  input  logic                                neg_i,
  input  logic        [dpm_pkg::MAG_W-1:0]    deadzone_i,
  input  logic        [dpm_pkg::DUTY_W-1:0]   duty_floor_i,
  output dpm_pkg::dpm_lane_res_t              res_o
);

  localparam int unsigned NS = dpm_pkg::DIV_STAGES;

  logic signed [dpm_pkg::CMD_W:0]    s_cmd;
  logic signed [dpm_pkg::CMD_W:0]    s_dz;
  logic        [dpm_pkg::CMD_W:0]    s_abs;
  logic        [dpm_pkg::MAG_W-1:0]  s_mag;
  logic        [dpm_pkg::MAG_W-1:0]  den;
  logic        [dpm_pkg::DUTY_W-1:0] span;
  dpm_pkg::dpm_flags_t               flg_d;

  logic [dpm_pkg::MAG_W-1:0]  diff_q;
  dpm_pkg::dpm_flags_t        flg0_q;
  logic [dpm_pkg::PROD_W-1:0] prod_q;
  dpm_pkg::dpm_flags_t        flg1_q;

  logic [dpm_pkg::REM_W-1:0]  rem_q [NS+1];
  logic [dpm_pkg::DUTY_W-1:0] quo_q [NS+1];
  dpm_pkg::dpm_flags_t        flg_q [NS+1];

  // Signed command after mounting sign, magnitude clamp and direction
  always_comb begin
    s_cmd = neg_i ? -{cmd_i[dpm_pkg::CMD_W-1], cmd_i}
                  :  {cmd_i[dpm_pkg::CMD_W-1], cmd_i};
    s_dz  = $signed({2'b00, deadzone_i});
    s_abs = s_cmd[dpm_pkg::CMD_W] ? (dpm_pkg::CMD_W+1)'(-s_cmd)
                                  : (dpm_pkg::CMD_W+1)'(s_cmd);
    s_mag = (s_abs > (dpm_pkg::CMD_W+1)'(dpm_pkg::FULL_CMD)) ? dpm_pkg::FULL_CMD
                                                             : s_abs[dpm_pkg::MAG_W-1:0];
    flg_d.fwd   = s_cmd > s_dz;
    flg_d.rev   = s_cmd < -s_dz;
    flg_d.zspan = deadzone_i == dpm_pkg::FULL_CMD;
    den  = dpm_pkg::FULL_CMD - deadzone_i;
    span = dpm_pkg::FULL_DUTY - duty_floor_i;
  end

  // Capture magnitude above the deadzone
  always_ff @(posedge clk_i) begin
    diff_q <= s_mag - deadzone_i;
    flg0_q <= flg_d;
  end

  // Scale by the duty span
  always_ff @(posedge clk_i) begin
    prod_q <= dpm_pkg::PROD_W'(diff_q * span);
    flg1_q <= flg0_q;
  end

  // Form the rounded dividend
  always_ff @(posedge clk_i) begin
    rem_q[0] <= dpm_pkg::REM_W'({prod_q, 1'b0}) + dpm_pkg::REM_W'(den);
    quo_q[0] <= '0;
    flg_q[0] <= flg1_q;
  end

  // Restoring divider, one quotient bit a stage, MSB first
  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int unsigned SH = NS - 1 - k;
    logic [dpm_pkg::REM_W-1:0] dsh;
    logic [dpm_pkg::REM_W:0]   trial;

    always_comb begin
      dsh   = dpm_pkg::REM_W'({den, 1'b0}) << SH;
      trial = {1'b0, rem_q[k]} - {1'b0, dsh};
    end

    always_ff @(posedge clk_i) begin
      if (!trial[dpm_pkg::REM_W]) begin
        rem_q[k+1] <= trial[dpm_pkg::REM_W-1:0];
        quo_q[k+1] <= quo_q[k] | (dpm_pkg::DUTY_W'(1) << SH);
      end else begin
        rem_q[k+1] <= rem_q[k];
        quo_q[k+1] <= quo_q[k];
      end
      flg_q[k+1] <= flg_q[k];
    end
  end

  // Add the floor; a deadzone spanning the full command range drives full duty
  always_comb begin
    res_o.fwd  = flg_q[NS].fwd;
    res_o.rev  = flg_q[NS].rev;
    res_o.duty = flg_q[NS].zspan ? dpm_pkg::FULL_DUTY : duty_floor_i + quo_q[NS];
  end

endmodule

>>> rtl/core/dpm_merge.sv
module dpm_merge #(
  parameter int unsigned WHEEL_COUNT = dpm_pkg::DEFAULT_WHEELS
) (
  input  logic                              clk_i,
  input  dpm_pkg::dpm_lane_res_t            res_i [WHEEL_COUNT],
  input  logic [dpm_pkg::CHAN_W-1:0]        wheel_channels_i,
  output dpm_pkg::dpm_duty_t                duty_o [dpm_pkg::CHANNELS]
);

  dpm_pkg::dpm_duty_t duty_d [dpm_pkg::CHANNELS];
  dpm_pkg::dpm_duty_t duty_q [dpm_pkg::CHANNELS];

  // Place each wheel on its pair; later wheels overwrite
  always_comb begin
    logic [dpm_pkg::PAIR_W-1:0] pair;
    logic [2:0]                 ch;
    for (int c = 0; c < dpm_pkg::CHANNELS; c++) begin
      duty_d[c] = '0;
    end
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      pair = wheel_channels_i[dpm_pkg::PAIR_W*w +: dpm_pkg::PAIR_W];
      ch   = {pair[1:0], 1'b0};
      if (!pair[2]) begin
        duty_d[ch]        = res_i[w].fwd ? res_i[w].duty : '0;
        duty_d[ch | 3'd1] = res_i[w].rev ? res_i[w].duty : '0;
      end
    end
  end

  // Hold the result for the strobe cycle
  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
  end

  assign duty_o = duty_q;

endmodule

>>> rtl/core/diff_drive_pwm_mixer.sv
// Differential drive PWM mixer. A request (left_cmd_i, right_cmd_i) is taken
// on any cycle where start is high; busy stays low, so a new request may follow
// every cycle. Each request yields one set of eight channel duties on
// duty_ch*_o, shown for exactly one cycle with done_o high, after the request
// passes the sign, scale and round steps, the per-wheel restoring divider (one
// quotient bit per stage) and the channel merge. The receiver cannot stall;
// results are not buffered. The user must write registers over the APB port
// only while no request is in flight; the block itself does not enforce this.
`include "diff_drive_pwm_mixer_defines.svh"

module diff_drive_pwm_mixer #(
  parameter int unsigned WHEEL_COUNT = dpm_pkg::DEFAULT_WHEELS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [dpm_pkg::CMD_W-1:0]     left_cmd_i,
  input  logic signed [dpm_pkg::CMD_W-1:0]     right_cmd_i,
  // result channel
  output logic                                 done_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch0_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch1_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch2_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch3_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch4_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch5_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch6_o,
  output logic        [dpm_pkg::DUTY_W-1:0]    duty_ch7_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [dpm_pkg::PADDR_W-1:0]   paddr,
  input  logic        [dpm_pkg::PDATA_W-1:0]   pwdata,
  output logic        [dpm_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);

  localparam int unsigned LAT = 3 + dpm_pkg::DIV_STAGES + 1;

  logic [dpm_pkg::MAG_W-1:0]  deadzone_q;
  logic [dpm_pkg::DUTY_W-1:0] duty_floor_q;
  logic [dpm_pkg::CHAN_W-1:0] wheel_channels_q;
  logic [dpm_pkg::SIGN_W-1:0] wheel_signs_q;

  dpm_pkg::dpm_reg_e          reg_sel;
  logic                       cfg_wr;
  logic                       accept;
  logic [LAT-1:0]             vld_q;
  logic [LAT-1:0]             vld_d;

  dpm_pkg::dpm_lane_res_t     lane_res [WHEEL_COUNT];
  dpm_pkg::dpm_duty_t         duty     [dpm_pkg::CHANNELS];

  // Register access decode
  assign reg_sel = dpm_pkg::dpm_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q       <= dpm_pkg::DEADZONE_RST;
      duty_floor_q     <= dpm_pkg::FLOOR_RST;
      wheel_channels_q <= dpm_pkg::CHAN_RST;
      wheel_signs_q    <= dpm_pkg::SIGNS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        dpm_pkg::REG_DEADZONE: deadzone_q       <= pwdata[dpm_pkg::MAG_W-1:0];
        dpm_pkg::REG_FLOOR:    duty_floor_q     <= pwdata[dpm_pkg::DUTY_W-1:0];
        dpm_pkg::REG_CHANNELS: wheel_channels_q <= pwdata[dpm_pkg::CHAN_W-1:0];
        dpm_pkg::REG_SIGNS:    wheel_signs_q    <= pwdata[dpm_pkg::SIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      dpm_pkg::REG_DEADZONE: prdata = dpm_pkg::PDATA_W'(deadzone_q);
      dpm_pkg::REG_FLOOR:    prdata = dpm_pkg::PDATA_W'(duty_floor_q);
      dpm_pkg::REG_CHANNELS: prdata = dpm_pkg::PDATA_W'(wheel_channels_q);
      dpm_pkg::REG_SIGNS:    prdata = dpm_pkg::PDATA_W'(wheel_signs_q);
      default:               prdata = '0;
    endcase
  end

  // Fully pipelined: never stall the request side
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Track requests through the lanes and the merge
  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[LAT-1];

  // One lane per wheel; even wheels follow left, odd wheels follow right
  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    dpm_lane u_lane (
      .clk_i        (clk_i),
      .cmd_i        ((w % 2 == 1) ? right_cmd_i : left_cmd_i),
      .neg_i        (wheel_signs_q[w]),
      .deadzone_i   (deadzone_q),
      .duty_floor_i (duty_floor_q),
      .res_o        (lane_res[w])
    );
  end

  dpm_merge #(
    .WHEEL_COUNT (WHEEL_COUNT)
  ) u_merge (
    .clk_i            (clk_i),
    .res_i            (lane_res),
    .wheel_channels_i (wheel_channels_q),
    .duty_o           (duty)
  );

  assign duty_ch0_o = duty[0];
  assign duty_ch1_o = duty[1];
  assign duty_ch2_o = duty[2];
  assign duty_ch3_o = duty[3];
  assign duty_ch4_o = duty[4];
  assign duty_ch5_o = duty[5];
  assign duty_ch6_o = duty[6];
  assign duty_ch7_o = duty[7];

  // Every request comes back after the full pipeline depth
  `DPM_ASSERT_DLY(a_req_done, accept, 16, done_o, "request did not complete in 16 cycles")

  // A pair never drives both legs at once
  `DPM_ASSERT_IMP(a_pair_legs, done_o, (duty_ch0_o == '0 || duty_ch1_o == '0) && (duty_ch2_o == '0 || duty_ch3_o == '0) && (duty_ch4_o == '0 || duty_ch5_o == '0) && (duty_ch6_o == '0 || duty_ch7_o == '0), "both legs of a pair driven")

  // With every wheel disabled all channels stay off
  `DPM_ASSERT_IMP(a_all_off, done_o && wheel_channels_q[2] && wheel_channels_q[5] && wheel_channels_q[8] && wheel_channels_q[11], duty_ch0_o == '0 && duty_ch1_o == '0 && duty_ch2_o == '0 && duty_ch3_o == '0 && duty_ch4_o == '0 && duty_ch5_o == '0 && duty_ch6_o == '0 && duty_ch7_o == '0, "disabled wheels drove a channel")

endmodule
